[rtl/qalu_pkg.sv]
package qalu_pkg;

  localparam int COMP_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int KIND_WIDTH     = 5;
  localparam int TOL_WIDTH      = 16;

  // operation codes
  typedef enum logic [KIND_WIDTH-1:0] {
    K_ADD     = 5'd0,
    K_SUB     = 5'd1,
    K_MUL     = 5'd2,
    K_DIV     = 5'd3,
    K_NEG     = 5'd4,
    K_CONJ    = 5'd5,
    K_RECIP   = 5'd6,
    K_NORMSQ  = 5'd7,
    K_NORM    = 5'd8,
    K_SETNORM = 5'd9,
    K_EQ      = 5'd10,
    K_NE      = 5'd11,
    K_GT      = 5'd12,
    K_LT      = 5'd13,
    K_GE      = 5'd14,
    K_LE      = 5'd15,
    K_INC     = 5'd16,
    K_DEC     = 5'd17
  } kind_t;

  // per-item control that travels down the pipeline
  typedef struct packed {
    kind_t kind;
    logic  cmp;
    logic  zd;
    logic  sat;
  } ctl_t;

  // Hamilton product: component c, term t uses a[t] * b[c ^ t];
  // bit c*4+t set where that term is subtracted
  localparam logic [15:0] TERM_NEG = 16'b0100_0010_1000_1110;

  // operations that take the product with the conjugate of b
  function automatic logic is_dv(input kind_t k);
    return (k == K_DIV) || (k == K_RECIP);
  endfunction

  // operations whose result comes out of the divider
  function automatic logic is_quot(input kind_t k);
    return (k == K_DIV) || (k == K_RECIP) || (k == K_SETNORM);
  endfunction

endpackage

[rtl/qalu_front.sv]
module qalu_front #(
  parameter int CW = qalu_pkg::COMP_WIDTH_DEF,
  parameter int FB = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [qalu_pkg::KIND_WIDTH-1:0]   in_kind,
  input  logic [3:0][CW-1:0]                in_a,
  input  logic [3:0][CW-1:0]                in_b,
  input  logic [CW-2:0]                     in_scal,
  input  logic [qalu_pkg::TOL_WIDTH-1:0]    tol,
  output logic                              out_valid,
  output qalu_pkg::ctl_t                    ctl_o,
  output logic [3:0][CW-1:0]                res_o,
  output logic [3:0][2*CW+FB:0]             num_o,
  output logic [3:0]                        neg_o,
  output logic [2*CW:0]                     nsq_o
);
  import qalu_pkg::*;

  localparam int PW   = 2*CW;
  localparam int SUMW = 2*CW+2;
  localparam int NSQW = 2*CW+1;
  localparam int NUMW = 2*CW+1+FB;

  localparam logic signed [CW:0] ONE_E = {{(CW-FB){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic signed [CW:0] MAX_E = {2'b00, {(CW-1){1'b1}}};
  localparam logic signed [CW:0] MIN_E = {2'b11, {(CW-1){1'b0}}};
  localparam logic [SUMW-1:0] HALF_W = {{(SUMW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [SUMW-1:0] MAX_W = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] MIN_W = {{(SUMW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [NSQW-1:0] HALF_N = {{(NSQW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic [NSQW-1:0] MAX_N  = {{(NSQW-CW+1){1'b0}}, {(CW-1){1'b1}}};

  // stage 1: input register
  logic              v1;
  kind_t             kind1;
  logic [3:0][CW-1:0] a1, b1;
  logic [CW-2:0]     scal1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    kind1 <= kind_t'(in_kind);
    a1    <= in_a;
    b1    <= in_b;
    scal1 <= in_scal;
  end

  // stage 2 logic: operand select, short ops, compares
  logic [3:0][CW-1:0] pa, qv, mag;
  logic signed [CW:0] sa [4];
  logic signed [CW:0] sb [4];
  logic signed [CW:0] e  [4];
  logic signed [CW+1:0] dd [4];
  logic [CW+1:0]      ad [4];
  logic [3:0]         hold;
  logic [3:0][CW-1:0] dres;
  logic [3:0]         dsat;
  ctl_t               ctl2_next;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pa[c]  = (kind1 == K_RECIP) ? ((c == 0) ? ONE_E[CW-1:0] : '0) : a1[c];
      qv[c]  = is_dv(kind1) ? b1[c] : a1[c];
      mag[c] = a1[c][CW-1] ? (~a1[c] + 1'b1) : a1[c];
      sa[c]  = $signed({a1[c][CW-1], a1[c]});
      sb[c]  = $signed({b1[c][CW-1], b1[c]});
      case (kind1)
        K_ADD:   e[c] = sa[c] + sb[c];
        K_SUB:   e[c] = sa[c] - sb[c];
        K_NEG:   e[c] = -sa[c];
        K_CONJ:  e[c] = (c == 0) ? sa[c] : -sa[c];
        K_INC:   e[c] = (c == 0) ? sa[c] + ONE_E : sa[c];
        K_DEC:   e[c] = (c == 0) ? sa[c] - ONE_E : sa[c];
        default: e[c] = '0;
      endcase
      // clip to the component range
      if (e[c] > MAX_E) begin
        dres[c] = MAX_E[CW-1:0];
        dsat[c] = 1'b1;
      end else if (e[c] < MIN_E) begin
        dres[c] = MIN_E[CW-1:0];
        dsat[c] = 1'b1;
      end else begin
        dres[c] = e[c][CW-1:0];
        dsat[c] = 1'b0;
      end
      // difference spans two bits beyond a component
      dd[c] = sa[c] - sb[c];
      ad[c] = dd[c][CW+1] ? (~dd[c] + 1'b1) : dd[c];
      case (kind1)
        K_GT:    hold[c] = sa[c] > sb[c];
        K_LT:    hold[c] = sa[c] < sb[c];
        K_GE:    hold[c] = sa[c] >= sb[c];
        K_LE:    hold[c] = sa[c] <= sb[c];
        default: hold[c] = ad[c] <= (CW+2)'(tol);
      endcase
    end
    ctl2_next.kind = kind1;
    ctl2_next.sat  = |dsat;
    case (kind1)
      K_EQ, K_GT, K_LT, K_GE, K_LE: ctl2_next.cmp = &hold;
      K_NE:                         ctl2_next.cmp = ~&hold;
      default:                      ctl2_next.cmp = 1'b0;
    endcase
    ctl2_next.zd = (is_dv(kind1) && (b1 == '0)) || ((kind1 == K_SETNORM) && (a1 == '0));
  end

  // stage 2: products
  logic                     v2;
  ctl_t                     ctl2;
  logic [3:0][CW-1:0]       dres2;
  logic signed [PW-1:0]     p2  [4][4];
  logic signed [PW-1:0]     sq2 [4];
  logic [PW-1:0]            ms2 [4];
  logic [3:0]               sgn2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ctl2  <= ctl2_next;
    dres2 <= dres;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p2[i][j] <= $signed(pa[i]) * $signed(b1[j]);
      end
      sq2[i]  <= $signed(qv[i]) * $signed(qv[i]);
      ms2[i]  <= PW'(mag[i]) * PW'(scal1);
      sgn2[i] <= a1[i][CW-1];
    end
  end

  // stage 3 logic: signed sums of the product terms
  logic signed [SUMW-1:0] wsum [4];
  logic signed [SUMW-1:0] pe;
  logic [1:0]             tb;
  logic                   ng;
  logic [NSQW-1:0]        nsum;

  always_comb begin
    pe   = '0;
    tb   = '0;
    ng   = 1'b0;
    nsum = '0;
    for (int c = 0; c < 4; c++) begin
      wsum[c] = '0;
      for (int t = 0; t < 4; t++) begin
        tb = 2'(c) ^ 2'(t);
        ng = TERM_NEG[c*4+t] ^ (is_dv(ctl2.kind) && (tb != 2'd0));
        pe = SUMW'(p2[t][tb]);
        wsum[c] = ng ? wsum[c] - pe : wsum[c] + pe;
      end
      nsum = nsum + NSQW'($unsigned(sq2[c]));
    end
  end

  // stage 3 registers
  logic                   v3;
  ctl_t                   ctl3;
  logic [3:0][CW-1:0]     dres3;
  logic signed [SUMW-1:0] w3 [4];
  logic [NSQW-1:0]        nsq3;
  logic [PW-1:0]          ms3 [4];
  logic [3:0]             sgn3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ctl3  <= ctl2;
    dres3 <= dres2;
    w3    <= wsum;
    nsq3  <= nsum;
    ms3   <= ms2;
    sgn3  <= sgn2;
  end

  // stage 4 logic: rounding for products, divider operands
  logic signed [SUMW-1:0] rr [4];
  logic [SUMW-1:0]        wm [4];
  logic [NSQW-1:0]        nr;
  logic [3:0][CW-1:0]     res4_next;
  logic [3:0][NUMW-1:0]   num4_next;
  logic [3:0]             neg4_next;
  logic [3:0]             msat;
  logic                   nsat;
  ctl_t                   ctl4_next;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rr[c] = (w3[c] + $signed(HALF_W)) >>> FB;
      if (rr[c] > MAX_W) begin
        res4_next[c] = MAX_W[CW-1:0];
        msat[c] = 1'b1;
      end else if (rr[c] < MIN_W) begin
        res4_next[c] = MIN_W[CW-1:0];
        msat[c] = 1'b1;
      end else begin
        res4_next[c] = rr[c][CW-1:0];
        msat[c] = 1'b0;
      end
      wm[c] = w3[c][SUMW-1] ? (~w3[c] + 1'b1) : w3[c];
      if (ctl3.kind == K_SETNORM) begin
        num4_next[c] = NUMW'(ms3[c]);
        neg4_next[c] = sgn3[c];
      end else begin
        num4_next[c] = NUMW'(wm[c][SUMW-2:0]) << FB;
        neg4_next[c] = w3[c][SUMW-1];
      end
    end
    nr   = (nsq3 + HALF_N) >> FB;
    nsat = nr > MAX_N;
    ctl4_next = ctl3;
    case (ctl3.kind)
      K_MUL: begin
        ctl4_next.sat = |msat;
      end
      K_NORMSQ: begin
        res4_next = '0;
        res4_next[0] = nsat ? MAX_N[CW-1:0] : nr[CW-1:0];
        ctl4_next.sat = nsat;
      end
      default: begin
        res4_next = dres3;
      end
    endcase
  end

  // stage 4 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ctl_o <= ctl4_next;
    res_o <= res4_next;
    num_o <= num4_next;
    neg_o <= neg4_next;
    nsq_o <= nsq3;
  end

endmodule

[rtl/qalu_sqrt.sv]
module qalu_sqrt #(
  parameter int XW   = 2*qalu_pkg::COMP_WIDTH_DEF+1,
  parameter int PAYW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [XW-1:0]        x,
  input  logic [PAYW-1:0]      pay_i,
  output logic                 out_valid,
  output logic [(XW+1)/2-1:0]  root,
  output logic [PAYW-1:0]      pay_o
);
  import qalu_pkg::*;

  localparam int RW = (XW+1)/2;

  // one result bit per stage, two radicand bits consumed per stage
  logic [RW-1:0]   vld;
  logic [2*RW-1:0] r_x   [RW];
  logic [RW+1:0]   r_rem [RW];
  logic [RW-1:0]   r_rt  [RW];
  logic [PAYW-1:0] r_pay [RW];

  logic [2*RW-1:0] s_x   [RW];
  logic [RW+1:0]   s_rem [RW];
  logic [RW-1:0]   s_rt  [RW];
  logic [PAYW-1:0] s_pay [RW];
  logic [RW+1:0]   t     [RW];
  logic [RW+1:0]   trial [RW];
  logic [RW-1:0]   ge;

  // stage inputs
  always_comb begin
    s_x[0]   = (2*RW)'(x);
    s_rem[0] = '0;
    s_rt[0]  = '0;
    s_pay[0] = pay_i;
    for (int i = 1; i < RW; i++) begin
      s_x[i]   = r_x[i-1];
      s_rem[i] = r_rem[i-1];
      s_rt[i]  = r_rt[i-1];
      s_pay[i] = r_pay[i-1];
    end
  end

  // trial subtract per stage
  always_comb begin
    for (int i = 0; i < RW; i++) begin
      t[i]     = {s_rem[i][RW-1:0], s_x[i][2*RW-1 -: 2]};
      trial[i] = {s_rt[i], 2'b01};
      ge[i]    = t[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[RW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RW; i++) begin
      r_rem[i] <= ge[i] ? t[i] - trial[i] : t[i];
      r_rt[i]  <= {s_rt[i][RW-2:0], ge[i]};
      r_x[i]   <= s_x[i] << 2;
      r_pay[i] <= s_pay[i];
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = r_rt[RW-1];
  assign pay_o     = r_pay[RW-1];

endmodule

[rtl/qalu_div.sv]
module qalu_div #(
  parameter int NUMW = 2*qalu_pkg::COMP_WIDTH_DEF+1+qalu_pkg::FRAC_BITS_DEF,
  parameter int DENW = 2*qalu_pkg::COMP_WIDTH_DEF+1,
  parameter int QW   = qalu_pkg::COMP_WIDTH_DEF,
  parameter int PAYW = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [3:0][NUMW-1:0]  num,
  input  logic [DENW-1:0]       den,
  input  logic [PAYW-1:0]       pay_i,
  output logic                  out_valid,
  output logic [3:0][QW-1:0]    quo,
  output logic [3:0]            ovf,
  output logic [PAYW-1:0]       pay_o
);
  import qalu_pkg::*;

  // stage 0 checks for quotient overflow, stages 1..QW make one bit each
  logic [QW:0]              vld;
  logic [3:0][DENW-1:0]     r_rem [QW+1];
  logic [3:0][QW-1:0]       r_lo  [QW+1];
  logic [3:0][QW-1:0]       r_q   [QW+1];
  logic [3:0]               r_ovf [QW+1];
  logic [DENW-1:0]          r_den [QW+1];
  logic [PAYW-1:0]          r_pay [QW+1];

  logic [3:0][DENW:0]       t    [QW+1];
  logic [3:0][DENW:0]       diff [QW+1];
  logic [3:0]               ge   [QW+1];

  always_comb begin
    for (int i = 0; i < QW+1; i++) begin
      t[i]    = '0;
      diff[i] = '0;
      ge[i]   = '0;
    end
    for (int i = 1; i < QW+1; i++) begin
      for (int l = 0; l < 4; l++) begin
        t[i][l]    = {r_rem[i-1][l], r_lo[i-1][l][QW-1]};
        diff[i][l] = t[i][l] - {1'b0, r_den[i-1]};
        ge[i][l]   = t[i][l] >= {1'b0, r_den[i-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // overflow check and initial remainder
    for (int l = 0; l < 4; l++) begin
      r_ovf[0][l] <= (num[l] >> QW) >= NUMW'(den);
      r_rem[0][l] <= DENW'(num[l] >> QW);
      r_lo[0][l]  <= num[l][QW-1:0];
      r_q[0][l]   <= '0;
    end
    r_den[0] <= den;
    r_pay[0] <= pay_i;
    // restoring steps
    for (int i = 1; i < QW+1; i++) begin
      for (int l = 0; l < 4; l++) begin
        r_rem[i][l] <= ge[i][l] ? diff[i][l][DENW-1:0] : t[i][l][DENW-1:0];
        r_q[i][l]   <= {r_q[i-1][l][QW-2:0], ge[i][l]};
        r_lo[i][l]  <= r_lo[i-1][l] << 1;
      end
      r_ovf[i] <= r_ovf[i-1];
      r_den[i] <= r_den[i-1];
      r_pay[i] <= r_pay[i-1];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = r_q[QW];
  assign ovf       = r_ovf[QW];
  assign pay_o     = r_pay[QW];

endmodule

[rtl/quaternion_alu.sv]
// From start to done an item passes the front end, the square root, the divider and the output register.
// Throughput: one item per cycle; busy stays low and results are never held.
// Depth is set by the square-root recurrence (COMP_WIDTH+1 stages, one bit per stage)
// and the four-lane restoring divider (COMP_WIDTH+1 stages: an overflow check, then one bit per stage).
// Reset (rst, synchronous) clears all pipeline valid bits and the tolerance register (tol).
module quaternion_alu #(
  parameter int COMP_WIDTH = qalu_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [qalu_pkg::KIND_WIDTH-1:0]    kind,
  input  logic [COMP_WIDTH-1:0]              a_re,
  input  logic [COMP_WIDTH-1:0]              a_i,
  input  logic [COMP_WIDTH-1:0]              a_j,
  input  logic [COMP_WIDTH-1:0]              a_k,
  input  logic [COMP_WIDTH-1:0]              b_re,
  input  logic [COMP_WIDTH-1:0]              b_i,
  input  logic [COMP_WIDTH-1:0]              b_j,
  input  logic [COMP_WIDTH-1:0]              b_k,
  input  logic [COMP_WIDTH-2:0]              scalar,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qalu_pkg::TOL_WIDTH-1:0]     cfg_data,
  output logic                               done,
  output logic [COMP_WIDTH-1:0]              r_re,
  output logic [COMP_WIDTH-1:0]              r_i,
  output logic [COMP_WIDTH-1:0]              r_j,
  output logic [COMP_WIDTH-1:0]              r_k,
  output logic                               compare_true,
  output logic                               zero_divisor,
  output logic                               saturated
);
  import qalu_pkg::*;

  localparam int CW      = COMP_WIDTH;
  localparam int NSQW    = 2*CW+1;
  localparam int NUMW    = 2*CW+1+FRAC_BITS;
  localparam int RW      = CW+1;
  localparam int CTLW    = $bits(ctl_t);
  localparam int PAY1W   = CTLW + 4*CW + 4 + 4*NUMW + NSQW;
  localparam int PAY2W   = CTLW + 4*CW + 4;
  localparam int LATENCY = 2*CW+7;
  localparam logic [RW-1:0] MAX_R = {2'b00, {(CW-1){1'b1}}};

  // never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // tolerance register
  logic [TOL_WIDTH-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  // front end: products, sums, short operations
  logic                 f_valid;
  ctl_t                 f_ctl;
  logic [3:0][CW-1:0]   f_res;
  logic [3:0][NUMW-1:0] f_num;
  logic [3:0]           f_neg;
  logic [NSQW-1:0]      f_nsq;

  qalu_front #(
    .CW (CW),
    .FB (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_kind   (kind),
    .in_a      ({a_k, a_j, a_i, a_re}),
    .in_b      ({b_k, b_j, b_i, b_re}),
    .in_scal   (scalar),
    .tol       (tol),
    .out_valid (f_valid),
    .ctl_o     (f_ctl),
    .res_o     (f_res),
    .num_o     (f_num),
    .neg_o     (f_neg),
    .nsq_o     (f_nsq)
  );

  // square root of the squared norm
  logic                 s_valid;
  logic [RW-1:0]        s_root;
  logic [PAY1W-1:0]     s_pay;
  ctl_t                 s_ctl;
  logic [3:0][CW-1:0]   s_res;
  logic [3:0]           s_neg;
  logic [3:0][NUMW-1:0] s_num;
  logic [NSQW-1:0]      s_nsq;

  qalu_sqrt #(
    .XW   (NSQW),
    .PAYW (PAY1W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .x         (f_nsq),
    .pay_i     ({f_ctl, f_res, f_neg, f_num, f_nsq}),
    .out_valid (s_valid),
    .root      (s_root),
    .pay_o     (s_pay)
  );

  assign {s_ctl, s_res, s_neg, s_num, s_nsq} = s_pay;

  // norm result and divisor select
  ctl_t               d_ctl_in;
  logic [3:0][CW-1:0] d_res_in;
  logic [NSQW-1:0]    d_den;

  always_comb begin
    d_ctl_in = s_ctl;
    d_res_in = s_res;
    d_den    = is_dv(s_ctl.kind) ? s_nsq : NSQW'(s_root);
    if (s_ctl.kind == K_NORM) begin
      d_res_in     = '0;
      d_res_in[0]  = (s_root > MAX_R) ? MAX_R[CW-1:0] : s_root[CW-1:0];
      d_ctl_in.sat = s_root > MAX_R;
    end
  end

  // quotient lanes
  logic               q_valid;
  logic [3:0][CW-1:0] q_quo;
  logic [3:0]         q_ovf;
  logic [PAY2W-1:0]   q_pay;
  ctl_t               q_ctl;
  logic [3:0][CW-1:0] q_res;
  logic [3:0]         q_neg;

  qalu_div #(
    .NUMW (NUMW),
    .DENW (NSQW),
    .QW   (CW),
    .PAYW (PAY2W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .num       (s_num),
    .den       (d_den),
    .pay_i     ({d_ctl_in, d_res_in, s_neg}),
    .out_valid (q_valid),
    .quo       (q_quo),
    .ovf       (q_ovf),
    .pay_o     (q_pay)
  );

  assign {q_ctl, q_res, q_neg} = q_pay;

  // final select with quotient saturation
  logic [3:0][CW-1:0] lim, qv, out_next;
  logic [3:0]         lsat;
  logic               sat_next;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lim[l]  = q_neg[l] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      lsat[l] = q_ovf[l] || (q_quo[l] > lim[l]);
      qv[l]   = lsat[l] ? lim[l] : q_quo[l];
    end
    if (is_quot(q_ctl.kind)) begin
      for (int l = 0; l < 4; l++) begin
        out_next[l] = q_ctl.zd ? '0 : (q_neg[l] ? ~qv[l] + 1'b1 : qv[l]);
      end
      sat_next = !q_ctl.zd && (|lsat);
    end else begin
      out_next = q_res;
      sat_next = q_ctl.sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    r_re         <= out_next[0];
    r_i          <= out_next[1];
    r_j          <= out_next[2];
    r_k          <= out_next[3];
    compare_true <= q_ctl.cmp;
    zero_divisor <= q_ctl.zd;
    saturated    <= sat_next;
  end

  // a zero divisor gives an all-zero, unclipped result
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    done && zero_divisor |-> !saturated && r_re == '0 && r_i == '0 && r_j == '0 && r_k == '0)
    else $error("zero divisor result not cleared");

  // a true comparison carries no other flags and zero real and k components
  a_compare: assert property (@(posedge clk) disable iff (rst)
    done && compare_true |-> !zero_divisor && !saturated && r_re == '0 && r_k == '0)
    else $error("comparison result malformed");

  // every transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("result missing at pipeline latency");

endmodule
